/* rtl/core/psfd_pkg.sv */
// Package for the panel status frame decoder.
// Holds the phase and result types, register indexes and shared helpers.
// No dependencies.
package psfd_pkg;

    localparam int PSFD_MAX_CONTROLLERS     = 4;
    localparam int PSFD_PINS_PER_CONTROLLER = 24;

    localparam logic [7:0] HDR_BYTE = 8'h0B;
    localparam logic [4:0] MAX_ADC  = 5'd24;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_COUNTS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_LEN,
        PH_ADC,
        PH_PIN,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ADC    = 2'd0,
        KIND_PIN    = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  controller;
        logic [4:0]  item_index;
        logic [15:0] adc_value;
        logic [7:0]  pin_bits;
        logic        last;
    } t_result;

    // ADC word count of one section, saturated; sections beyond the fourth have none
    function automatic logic [4:0] adc_count_of(input logic [CFG_W-1:0] counts,
                                                 input logic [3:0] sec);
        logic [4:0] n;
        case (sec)
            4'd0:    n = counts[4:0];
            4'd1:    n = counts[9:5];
            4'd2:    n = counts[14:10];
            4'd3:    n = counts[19:15];
            default: n = 5'd0;
        endcase
        if (n > MAX_ADC) begin
            n = MAX_ADC;
        end
        return n;
    endfunction

endpackage

/* rtl/core/psfd_outq.sv */
// Two-entry result buffer: output register plus skid stage.
// Depends on psfd_pkg for the result struct.
module psfd_outq
    import psfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_main_valid && !i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

/* rtl/core/psfd_decode.sv */
// Frame decode state machine and configuration registers.
// Depends on psfd_pkg; produces at most one result per accepted byte.
module psfd_decode
    import psfd_pkg::*;
#(
    parameter int MAX_CONTROLLERS     = PSFD_MAX_CONTROLLERS,
    parameter int PINS_PER_CONTROLLER = PSFD_PINS_PER_CONTROLLER
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    output logic                 o_push,
    output t_result              o_result
);

    localparam int SEC_W     = (MAX_CONTROLLERS > 1) ? $clog2(MAX_CONTROLLERS) : 1;
    localparam int PIN_BYTES = (PINS_PER_CONTROLLER + 7) / 8;

    logic [2:0]       r_ctl_count;
    logic [CFG_W-1:0] r_adc_counts;
    logic [7:0]       r_pay_len;

    t_phase           r_phase, n_phase;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [4:0]       r_adc_idx, n_adc_idx;
    logic [1:0]       r_pin_idx, n_pin_idx;
    logic [7:0]       r_high, n_high;
    logic             r_half, n_half;

    logic [3:0]       sections;
    logic [4:0]       cur_cnt;
    logic [4:0]       nxt_cnt;
    logic             is_pin;
    logic [1:0]       pin_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_count  <= 3'd1;
            r_adc_counts <= '0;
            r_pay_len    <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONTROLLER_COUNT: r_ctl_count  <= i_cfg_data[2:0];
                CFG_ADC_COUNTS:       r_adc_counts <= i_cfg_data;
                CFG_PAYLOAD_LENGTH:   r_pay_len    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sections = 4'(r_ctl_count);
        if (sections == 4'd0) begin
            sections = 4'd1;
        end else if (sections > 4'(MAX_CONTROLLERS)) begin
            sections = 4'(MAX_CONTROLLERS);
        end
    end

    assign cur_cnt = adc_count_of(r_adc_counts, 4'(r_sec));
    assign nxt_cnt = adc_count_of(r_adc_counts, 4'(r_sec) + 4'd1);

    always_comb begin
        n_phase   = r_phase;
        n_sec     = r_sec;
        n_adc_idx = r_adc_idx;
        n_pin_idx = r_pin_idx;
        n_high    = r_high;
        n_half    = r_half;
        o_push    = 1'b0;
        o_result  = '{kind: KIND_ADC, controller: 2'd0, item_index: 5'd0,
                      adc_value: 16'd0, pin_bits: 8'd0, last: 1'b0};
        is_pin    = 1'b0;
        pin_use   = r_pin_idx;

        if (i_accept) begin
            if (i_frame_start) begin
                if (i_rx_byte != HDR_BYTE) begin
                    n_phase         = PH_IDLE;
                    o_push          = 1'b1;
                    o_result.kind   = KIND_REJECT;
                    o_result.last   = 1'b1;
                end else begin
                    n_phase = PH_HDR2;
                end
            end else begin
                case (r_phase)
                    PH_HDR2: begin
                        if (i_rx_byte != HDR_BYTE) begin
                            n_phase       = PH_IDLE;
                            o_push        = 1'b1;
                            o_result.kind = KIND_REJECT;
                            o_result.last = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (i_rx_byte != r_pay_len) begin
                            n_phase       = PH_IDLE;
                            o_push        = 1'b1;
                            o_result.kind = KIND_REJECT;
                            o_result.last = 1'b1;
                        end else begin
                            n_sec     = '0;
                            n_adc_idx = 5'd0;
                            n_pin_idx = 2'd0;
                            n_half    = 1'b0;
                            n_high    = 8'd0;
                            n_phase   = (adc_count_of(r_adc_counts, 4'd0) != 5'd0)
                                        ? PH_ADC : PH_PIN;
                        end
                    end
                    PH_ADC: begin
                        if (r_adc_idx >= cur_cnt) begin
                            // count lowered under us: this byte opens the pin bytes
                            is_pin  = 1'b1;
                            pin_use = 2'd0;
                        end else if (!r_half) begin
                            n_high = i_rx_byte;
                            n_half = 1'b1;
                        end else begin
                            n_half    = 1'b0;
                            n_adc_idx = r_adc_idx + 5'd1;
                            if (r_adc_idx + 5'd1 >= cur_cnt) begin
                                n_phase   = PH_PIN;
                                n_pin_idx = 2'd0;
                            end
                            o_push              = 1'b1;
                            o_result.kind       = KIND_ADC;
                            o_result.controller = 2'(r_sec);
                            o_result.item_index = r_adc_idx;
                            o_result.adc_value  = {r_high, i_rx_byte};
                        end
                    end
                    PH_PIN: begin
                        is_pin = 1'b1;
                    end
                    default: ;
                endcase
            end

            if (is_pin) begin
                n_pin_idx           = pin_use + 2'd1;
                o_push              = 1'b1;
                o_result.kind       = KIND_PIN;
                o_result.controller = 2'(r_sec);
                o_result.item_index = 5'(pin_use);
                o_result.pin_bits   = i_rx_byte;
                n_phase             = PH_PIN;
                if (3'(pin_use) + 3'd1 >= 3'(PIN_BYTES)) begin
                    if (4'(r_sec) + 4'd1 < sections) begin
                        n_sec     = r_sec + 1'b1;
                        n_adc_idx = 5'd0;
                        n_pin_idx = 2'd0;
                        n_half    = 1'b0;
                        n_high    = 8'd0;
                        n_phase   = (nxt_cnt != 5'd0) ? PH_ADC : PH_PIN;
                    end else begin
                        n_phase       = PH_DONE;
                        o_result.last = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_sec     <= '0;
            r_adc_idx <= 5'd0;
            r_pin_idx <= 2'd0;
            r_high    <= 8'd0;
            r_half    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_sec     <= n_sec;
            r_adc_idx <= n_adc_idx;
            r_pin_idx <= n_pin_idx;
            r_high    <= n_high;
            r_half    <= n_half;
        end
    end

endmodule

/* rtl/core/panel_status_frame_decoder_top.sv */
// Top level of the panel status frame decoder.
// Instantiates psfd_decode and psfd_outq; types from psfd_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_rx_byte, i_frame_start
//  out     | output    | o_out_valid / i_out_stall | o_result_kind .. o_last
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One byte item per cycle while o_in_stall is low; its result, if any, is
// registered in the output buffer. The rate is set by the single decode step
// between the input port and the two-entry output buffer. o_in_stall rises only
// when both buffer entries hold results. Reset is synchronous and active low.
module panel_status_frame_decoder_top
    import psfd_pkg::*;
#(
    parameter int MAX_CONTROLLERS     = PSFD_MAX_CONTROLLERS,
    parameter int PINS_PER_CONTROLLER = PSFD_PINS_PER_CONTROLLER
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_result_kind,
    output logic [1:0]           o_controller,
    output logic [4:0]           o_item_index,
    output logic [15:0]          o_adc_value,
    output logic [7:0]           o_pin_bits,
    output logic                 o_last
);

    logic    accept;
    logic    push;
    logic    full;
    t_result result;
    t_result out_data;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    psfd_decode #(
        .MAX_CONTROLLERS     (MAX_CONTROLLERS),
        .PINS_PER_CONTROLLER (PINS_PER_CONTROLLER)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_result      (result)
    );

    psfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    assign o_result_kind = out_data.kind;
    assign o_controller  = out_data.controller;
    assign o_item_index  = out_data.item_index;
    assign o_adc_value   = out_data.adc_value;
    assign o_pin_bits    = out_data.pin_bits;
    assign o_last        = out_data.last;

endmodule
